// ===== design/ljpe_pkg.sv =====
// Package for the Lennard-Jones particle energy block.
// Holds widths, register indexes, reset values and the control structs shared by
// the interfaces, the shared multiplier, the serial divider and the top level.
package ljpe_pkg;

  localparam int CFG_W    = 24;
  localparam int POS_W    = 24;
  localparam int IDX_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W    = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_LENGTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON_DEPTH = 2'd3;

  localparam logic [CFG_W-1:0] BOX_LENGTH_RST    = 24'd655360;
  localparam logic [CFG_W-1:0] CUTOFF_RADIUS_RST = 24'd196608;
  localparam logic [CFG_W-1:0] SIGMA_LENGTH_RST  = 24'd65536;
  localparam logic [CFG_W-1:0] EPSILON_DEPTH_RST = 24'd65536;

  localparam logic [SUM_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] NEG_MIN = 64'h8000_0000_0000_0000;
  localparam logic signed [SUM_W-1:0] NEAR_ZERO_LIMIT = 64'sd430;

  // Shared multiplier: 32-bit limbs, up to 2 x 3 limbs, 128-bit accumulator.
  localparam int LIMB_W  = 32;
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 96;
  localparam int MUL_P_W = 128;

  // Serial divider: Q32.32 quotient of a 48-bit numerator by a 50-bit divisor.
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 50;
  localparam int DIV_Q_W   = 64;
  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic       start;
    logic       a_last;   // index of the last limb of operand a
    logic [1:0] b_last;   // index of the last limb of operand b
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic ovf;
  } div_stat_t;

endpackage

// ===== design/ljpe_if.sv =====
// Handshake interfaces for the Lennard-Jones particle energy block.
// The item channel carries one particle pair, the result channel one sweep sum.
// Depends on ljpe_pkg for the field widths.
interface ljpe_item_if import ljpe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] ref_x;
  logic [POS_W-1:0] ref_y;
  logic [POS_W-1:0] ref_z;
  logic [POS_W-1:0] other_x;
  logic [POS_W-1:0] other_y;
  logic [POS_W-1:0] other_z;
  logic [IDX_W-1:0] ref_index;
  logic [IDX_W-1:0] other_index;
  logic             last_particle;

  modport source (
    output valid, ref_x, ref_y, ref_z, other_x, other_y, other_z,
    output ref_index, other_index, last_particle,
    input  ready
  );
  modport sink (
    input  valid, ref_x, ref_y, ref_z, other_x, other_y, other_z,
    input  ref_index, other_index, last_particle,
    output ready
  );
endinterface

interface ljpe_result_if import ljpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] energy_sum;
  logic                    near_zero_error;
  logic                    sum_saturated;

  modport source (
    output valid, energy_sum, near_zero_error, sum_saturated,
    input  ready
  );
  modport sink (
    input  valid, energy_sum, near_zero_error, sum_saturated,
    output ready
  );
endinterface

// ===== design/ljpe_mul.sv =====
// Shared limb multiplier: one 32 x 32 product per cycle, accumulated into a
// 128-bit register at the limb offset. Depends on ljpe_pkg.
module ljpe_mul import ljpe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               busy,
  output logic [MUL_P_W-1:0] product
);

  logic [MUL_A_W-1:0]  a_reg;
  logic [MUL_B_W-1:0]  b_reg;
  logic                a_last;
  logic [1:0]          b_last;
  logic                i;
  logic [1:0]          j;
  logic                issuing;
  logic                pend;
  logic [2*LIMB_W-1:0] pp;
  logic [1:0]          sh;
  logic [MUL_P_W-1:0]  acc;
  logic [LIMB_W-1:0]   a_limb;
  logic [LIMB_W-1:0]   b_limb;
  logic [MUL_P_W-1:0]  pp_shifted;

  always_comb begin
    a_limb = i ? a_reg[2*LIMB_W-1:LIMB_W] : a_reg[LIMB_W-1:0];
    unique case (j)
      2'd0:    b_limb = b_reg[LIMB_W-1:0];
      2'd1:    b_limb = b_reg[2*LIMB_W-1:LIMB_W];
      2'd2:    b_limb = b_reg[3*LIMB_W-1:2*LIMB_W];
      default: b_limb = '0;
    endcase
    pp_shifted = {{(MUL_P_W-2*LIMB_W){1'b0}}, pp} << {sh, 5'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      pend    <= 1'b0;
    end else if (req.start) begin
      a_reg   <= a;
      b_reg   <= b;
      a_last  <= req.a_last;
      b_last  <= req.b_last;
      i       <= 1'b0;
      j       <= 2'd0;
      issuing <= 1'b1;
      pend    <= 1'b0;
      acc     <= '0;
    end else begin
      pend <= issuing;
      if (issuing) begin
        pp <= a_limb * b_limb;
        sh <= {1'b0, i} + j;
        if (j == b_last) begin
          j <= 2'd0;
          if (i == a_last) begin
            issuing <= 1'b0;
          end else begin
            i <= 1'b1;
          end
        end else begin
          j <= j + 2'd1;
        end
      end
      if (pend) begin
        acc <= acc + pp_shifted;
      end
    end
  end

  assign busy    = issuing | pend;
  assign product = acc;

endmodule

// ===== design/ljpe_div.sv =====
// Restoring divider, one quotient bit per cycle: floor(num * 2^32 / den).
// An integer part wider than 32 bits is flagged at start. Depends on ljpe_pkg.
module ljpe_div import ljpe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output div_stat_t            stat,
  output logic [DIV_Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam int HI_W  = DIV_NUM_W - LIMB_W;

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_reg;
  logic [DIV_Q_W-1:0]   shreg;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 ovf;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   trial_sub;
  logic                 ge;
  logic [DIV_DEN_W-1:0] num_hi;

  always_comb begin
    num_hi    = {{(DIV_DEN_W-HI_W){1'b0}}, num[DIV_NUM_W-1:LIMB_W]};
    trial     = {rem, shreg[DIV_Q_W-1]};
    trial_sub = trial - {1'b0, den_reg};
    ge        = trial >= {1'b0, den_reg};
  end

  // The quotient bits enter at the bottom as the numerator bits leave the top.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ovf  <= 1'b0;
    end else if (start) begin
      ovf     <= num_hi >= den;
      busy    <= num_hi < den;
      rem     <= num_hi;
      shreg   <= {num[LIMB_W-1:0], {LIMB_W{1'b0}}};
      den_reg <= den;
      cnt     <= CNT_W'(DIV_STEPS);
    end else if (busy) begin
      rem   <= ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      shreg <= {shreg[DIV_Q_W-2:0], ge};
      cnt   <= cnt - CNT_W'(1);
      busy  <= cnt != CNT_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.ovf  = ovf;
  assign quotient  = shreg;

endmodule

// ===== design/lennard_jones_particle_energy.sv =====
// Lennard-Jones 12-6 energy of one chosen particle against a stream of others,
// with minimum-image wrapping in a cubic periodic box.
// Channels: "item" takes one pair (both positions, both indices, last flag) per
// request; "result" gives the sweep sum and two sticky flags after the request
// marked last_particle. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data), to be used only while the block is idle.
// Timing: one request at a time; item.ready is high only in the idle state.
// A self pair goes straight to the done state, and a pair outside the cutoff
// stops after the cutoff test. The serial divider forms sigma^2/r^2, and the
// shared 32 x 32 limb multiplier is used for the squares and the q^2, q^3,
// q^6 and epsilon products.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls and another last item completes, the block holds in
// its final state until the earlier result has been taken.
// Reset: synchronous; clears the sum, the flags and the output valid, and
// loads the register defaults (box 10.0, cutoff 3.0, sigma 1.0, eps 1.0).
module lennard_jones_particle_energy import ljpe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  ljpe_item_if.sink            item,
  ljpe_result_if.source        result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [20:0] {
    S_IDLE     = 21'h000001,
    S_WRAP     = 21'h000002,
    S_SQ       = 21'h000004,
    S_SQ_WAIT  = 21'h000008,
    S_CUT      = 21'h000010,
    S_CUT_WAIT = 21'h000020,
    S_SIG      = 21'h000040,
    S_SIG_WAIT = 21'h000080,
    S_DIV      = 21'h000100,
    S_DIV_WAIT = 21'h000200,
    S_Q2       = 21'h000400,
    S_Q2_WAIT  = 21'h000800,
    S_Q3       = 21'h001000,
    S_Q3_WAIT  = 21'h002000,
    S_Q6       = 21'h004000,
    S_Q6_WAIT  = 21'h008000,
    S_EPS      = 21'h010000,
    S_EPS_WAIT = 21'h020000,
    S_ADD      = 21'h040000,
    S_CHECK    = 21'h080000,
    S_DONE     = 21'h100000
  } state_t;

  localparam int D_W = POS_W + 1;
  localparam int W_W = POS_W + 2;
  localparam int R2_W = DIV_DEN_W;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  state_t state;

  logic [CFG_W-1:0] box;
  logic [CFG_W-1:0] cut;
  logic [CFG_W-1:0] sig;
  logic [CFG_W-1:0] eps;

  logic signed [SUM_W-1:0] sum;
  logic                    err;
  logic                    clamp;
  logic                    out_valid;
  logic signed [SUM_W-1:0] out_sum;
  logic                    out_err;
  logic                    out_clamp;

  logic signed [D_W-1:0] dx;
  logic signed [D_W-1:0] dy;
  logic signed [D_W-1:0] dz;
  logic                  last_item;
  logic [1:0]            ax;
  logic signed [W_W-1:0] dw;
  logic [R2_W-1:0]       r2;
  logic [DIV_Q_W-1:0]    qv;
  logic [DIV_Q_W-1:0]    qv2;
  logic [MUL_B_W-1:0]    dmag;
  logic                  neg;
  logic signed [SUM_W-1:0] term;

  mul_req_t           mul_req;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_busy;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start;
  div_stat_t          div_stat;
  logic [DIV_Q_W-1:0] div_q;

  logic                  accept;
  logic                  out_load;
  logic signed [D_W-1:0] dsel;
  logic signed [W_W-1:0] dsel_w;
  logic signed [W_W-1:0] d2;
  logic signed [W_W-1:0] len_w;
  logic signed [W_W-1:0] dw_next;
  logic [W_W-1:0]        dw_mag;
  logic [MUL_B_W:0]      q6_diff;
  logic [DIV_Q_W-1:0]    q3_minus_q6;
  logic                  term_big;
  logic [SUM_W-1:0]      term_mag;
  logic signed [SUM_W-1:0] add_raw;
  logic                  add_ovf;

  ljpe_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  ljpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (mul_prod[DIV_NUM_W-1:0]),
    .den      (r2),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign accept       = item.valid & item.ready;
  assign item.ready   = (state == S_IDLE);
  assign out_load     = (state == S_DONE) && last_item && (!out_valid || result.ready);
  assign result.valid = out_valid;
  assign result.energy_sum      = out_sum;
  assign result.near_zero_error = out_err;
  assign result.sum_saturated   = out_clamp;

  // Minimum image of one axis: one wrap by the box length at most.
  always_comb begin
    unique case (ax)
      2'd0:    dsel = dx;
      2'd1:    dsel = dy;
      default: dsel = dz;
    endcase
    dsel_w = {dsel[D_W-1], dsel};
    d2     = {dsel, 1'b0};
    len_w  = $signed({2'b00, box});
    if (d2 > len_w) begin
      dw_next = dsel_w - len_w;
    end else if (d2 < -len_w) begin
      dw_next = dsel_w + len_w;
    end else begin
      dw_next = dsel_w;
    end
    dw_mag = dw[W_W-1] ? W_W'(-dw) : W_W'(dw);
  end

  always_comb begin
    q6_diff     = {1'b0, mul_prod[MUL_P_W-1:LIMB_W]} - {{(MUL_B_W-DIV_Q_W+1){1'b0}}, qv2};
    q3_minus_q6 = qv2 - mul_prod[MUL_B_W-1:LIMB_W];
    term_big    = |mul_prod[MUL_P_W-1:77];
    term_mag    = mul_prod[77:14];
    add_raw     = sum + term;
    add_ovf     = (sum[SUM_W-1] == term[SUM_W-1]) && (add_raw[SUM_W-1] != sum[SUM_W-1]);
  end

  // Operand selection for the shared multiplier, and the divider start.
  always_comb begin
    mul_req   = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state)
      S_SQ: begin
        mul_req.start = 1'b1;
        mul_a = {{(MUL_A_W-W_W){1'b0}}, dw_mag};
        mul_b = {{(MUL_B_W-W_W){1'b0}}, dw_mag};
      end
      S_CUT: begin
        mul_req.start = 1'b1;
        mul_a = {{(MUL_A_W-CFG_W){1'b0}}, cut};
        mul_b = {{(MUL_B_W-CFG_W){1'b0}}, cut};
      end
      S_SIG: begin
        mul_req.start = 1'b1;
        mul_a = {{(MUL_A_W-CFG_W){1'b0}}, sig};
        mul_b = {{(MUL_B_W-CFG_W){1'b0}}, sig};
      end
      S_DIV: begin
        div_start = 1'b1;
      end
      S_Q2: begin
        mul_req = '{start: 1'b1, a_last: 1'b1, b_last: 2'd1};
        mul_a   = qv;
        mul_b   = {{(MUL_B_W-DIV_Q_W){1'b0}}, qv};
      end
      S_Q3: begin
        mul_req = '{start: 1'b1, a_last: 1'b1, b_last: 2'd1};
        mul_a   = qv2;
        mul_b   = {{(MUL_B_W-DIV_Q_W){1'b0}}, qv};
      end
      S_Q6: begin
        mul_req = '{start: 1'b1, a_last: 1'b1, b_last: 2'd1};
        mul_a   = qv2;
        mul_b   = {{(MUL_B_W-DIV_Q_W){1'b0}}, qv2};
      end
      S_EPS: begin
        mul_req = '{start: 1'b1, a_last: 1'b0, b_last: 2'd2};
        mul_a   = {{(MUL_A_W-CFG_W){1'b0}}, eps};
        mul_b   = dmag;
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      box       <= BOX_LENGTH_RST;
      cut       <= CUTOFF_RADIUS_RST;
      sig       <= SIGMA_LENGTH_RST;
      eps       <= EPSILON_DEPTH_RST;
      sum       <= '0;
      err       <= 1'b0;
      clamp     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BOX_LENGTH:    box <= cfg_data;
          REG_CUTOFF_RADIUS: cut <= cfg_data;
          REG_SIGMA_LENGTH:  sig <= cfg_data;
          REG_EPSILON_DEPTH: eps <= cfg_data;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dx        <= $signed({1'b0, item.other_x}) - $signed({1'b0, item.ref_x});
            dy        <= $signed({1'b0, item.other_y}) - $signed({1'b0, item.ref_y});
            dz        <= $signed({1'b0, item.other_z}) - $signed({1'b0, item.ref_z});
            last_item <= item.last_particle;
            ax        <= 2'd0;
            r2        <= '0;
            state     <= (item.ref_index == item.other_index) ? S_DONE : S_WRAP;
          end
        end
        S_WRAP: begin
          dw    <= dw_next;
          state <= S_SQ;
        end
        S_SQ: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (!mul_busy) begin
            r2 <= r2 + mul_prod[R2_W-1:0];
            if (ax == AXIS_LAST) begin
              state <= S_CUT;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_WRAP;
            end
          end
        end
        S_CUT: state <= S_CUT_WAIT;
        S_CUT_WAIT: begin
          if (!mul_busy) begin
            if (r2 >= {{(R2_W-2*CFG_W){1'b0}}, mul_prod[2*CFG_W-1:0]}) begin
              state <= S_DONE;
            end else if (eps == '0) begin
              term  <= '0;
              state <= S_ADD;
            end else if (r2 == '0) begin
              // Coincident particles: the term takes the largest positive value.
              term  <= POS_MAX;
              clamp <= 1'b1;
              state <= S_ADD;
            end else begin
              state <= S_SIG;
            end
          end
        end
        S_SIG: state <= S_SIG_WAIT;
        S_SIG_WAIT: begin
          if (!mul_busy) begin
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!div_stat.busy) begin
            if (div_stat.ovf) begin
              term  <= POS_MAX;
              clamp <= 1'b1;
              state <= S_ADD;
            end else begin
              qv    <= div_q;
              state <= S_Q2;
            end
          end
        end
        S_Q2: state <= S_Q2_WAIT;
        S_Q2_WAIT: begin
          if (!mul_busy) begin
            if (|mul_prod[MUL_P_W-1:MUL_B_W]) begin
              term  <= POS_MAX;
              clamp <= 1'b1;
              state <= S_ADD;
            end else begin
              qv2   <= mul_prod[MUL_B_W-1:LIMB_W];
              state <= S_Q3;
            end
          end
        end
        S_Q3: state <= S_Q3_WAIT;
        S_Q3_WAIT: begin
          if (!mul_busy) begin
            if (|mul_prod[MUL_P_W-1:MUL_B_W]) begin
              term  <= POS_MAX;
              clamp <= 1'b1;
              state <= S_ADD;
            end else begin
              qv2   <= mul_prod[MUL_B_W-1:LIMB_W];
              state <= S_Q6;
            end
          end
        end
        S_Q6: state <= S_Q6_WAIT;
        S_Q6_WAIT: begin
          if (!mul_busy) begin
            // q^6 is kept to 96 bits; a borrow means q^3 is the larger.
            neg <= q6_diff[MUL_B_W];
            if (q6_diff[MUL_B_W]) begin
              dmag <= {{(MUL_B_W-DIV_Q_W){1'b0}}, q3_minus_q6};
            end else begin
              dmag <= q6_diff[MUL_B_W-1:0];
            end
            state <= S_EPS;
          end
        end
        S_EPS: state <= S_EPS_WAIT;
        S_EPS_WAIT: begin
          if (!mul_busy) begin
            // 4 * eps in Q8.16 times a Q32.32 difference leaves 14 extra bits.
            if (term_big) begin
              term  <= neg ? $signed(NEG_MIN) : $signed(POS_MAX);
              clamp <= 1'b1;
            end else begin
              term <= neg ? $signed(-term_mag) : $signed(term_mag);
            end
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (add_ovf) begin
            sum   <= sum[SUM_W-1] ? $signed(NEG_MIN) : $signed(POS_MAX);
            clamp <= 1'b1;
          end else begin
            sum <= add_raw;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (sum < NEAR_ZERO_LIMIT && sum > -NEAR_ZERO_LIMIT) begin
            err <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!last_item) begin
            state <= S_IDLE;
          end else if (out_load) begin
            out_sum   <= sum;
            out_err   <= err;
            out_clamp <= clamp;
            sum       <= '0;
            err       <= 1'b0;
            clamp     <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lennard_jones_particle_energy: streams particle pairs
// through the item channel and checks each sweep sum against a built-in predictor
// or a typed expected result. Depends on ljpe_pkg, the ljpe interfaces and the block itself.
module tb_top import ljpe_pkg::*;;

  localparam int ONE          = 65536;   // 1.0 in Q8.16
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [POS_W-1:0] ref_x;
    logic [POS_W-1:0] ref_y;
    logic [POS_W-1:0] ref_z;
    logic [POS_W-1:0] other_x;
    logic [POS_W-1:0] other_y;
    logic [POS_W-1:0] other_z;
    logic [IDX_W-1:0] ref_index;
    logic [IDX_W-1:0] other_index;
    logic             last_particle;
  } pair_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] energy_sum;
    logic                    near_zero_error;
    logic                    sum_saturated;
  } sweep_result_t;

  typedef struct {
    pair_t         pair;
    bit            typed;
    sweep_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ljpe_item_if   item_ch ();
  ljpe_result_if result_ch ();

  lennard_jones_particle_energy i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and the sweep state.
  logic [CFG_W-1:0] cfg_box, cfg_cutoff, cfg_sigma, cfg_eps;
  logic [SUM_W-1:0] pred_sum;
  bit               pred_near, pred_clamp;

  sweep_result_t sweep_q[$];
  stim_row_t     directed_rows[$];
  int  fail_count = 0;
  bit  src_idle = 1'b1;
  bit  sink_idle = 1'b1;
  int  sink_stall = 0;
  bit  hold_go = 1'b0;
  bit  hold_off = 1'b0;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Per-axis difference wrapped once into the minimum image.
  function automatic longint wrap_delta(input logic [POS_W-1:0] other,
                                        input logic [POS_W-1:0] chosen);
    longint d, len;
    d   = longint'({40'b0, other}) - longint'({40'b0, chosen});
    len = longint'({40'b0, cfg_box});
    if (2 * d > len) d = d - len;
    else if (2 * d < -len) d = d + len;
    return d;
  endfunction

  function automatic logic [63:0] axis_sq(input longint d);
    logic [63:0] m;
    m = (d < 0) ? 64'(-d) : 64'(d);
    return m * m;
  endfunction

  // 4*eps*(q^6 - q^3) with q = sigma^2/r2, all in truncated fixed point.
  function automatic logic [63:0] lj_term(input logic [63:0] r2);
    logic [127:0] quo, prod, scaled;
    logic [63:0]  q, q2, q3;
    logic [95:0]  q6, diff;
    bit           neg;
    if (cfg_eps == 0) return '0;
    if (r2 == 0) begin
      pred_clamp = 1'b1;
      return POS_MAX;
    end
    quo = (128'(64'(cfg_sigma) * 64'(cfg_sigma)) << 32) / 128'(r2);
    if (quo[127:64] != 0) begin
      pred_clamp = 1'b1;
      return POS_MAX;
    end
    q = quo[63:0];
    prod = 128'(q) * 128'(q);
    if (prod[127:96] != 0) begin
      pred_clamp = 1'b1;
      return POS_MAX;
    end
    q2 = prod[95:32];
    prod = 128'(q2) * 128'(q);
    if (prod[127:96] != 0) begin
      pred_clamp = 1'b1;
      return POS_MAX;
    end
    q3 = prod[95:32];
    prod = 128'(q3) * 128'(q3);
    q6 = prod[127:32];
    if (q6 >= 96'(q3)) begin
      neg  = 1'b0;
      diff = q6 - 96'(q3);
    end else begin
      neg  = 1'b1;
      diff = 96'(q3) - q6;
    end
    scaled = (128'(cfg_eps) * 128'(diff)) >> 14;
    if (scaled > 128'(POS_MAX)) begin
      pred_clamp = 1'b1;
      return neg ? NEG_MIN : POS_MAX;
    end
    return neg ? (64'd0 - scaled[63:0]) : scaled[63:0];
  endfunction

  function automatic void accumulate_term(input logic [63:0] t);
    logic [63:0] s, mag;
    s = pred_sum + t;
    if (pred_sum[63] == t[63] && s[63] != pred_sum[63]) begin
      s = pred_sum[63] ? NEG_MIN : POS_MAX;
      pred_clamp = 1'b1;
    end
    pred_sum = s;
    mag = s[63] ? (64'd0 - s) : s;
    if (mag < 64'(NEAR_ZERO_LIMIT)) pred_near = 1'b1;
  endfunction

  // Advances the sweep state by one pair; returns 1 when a sum is due.
  function automatic bit predict_pair(input pair_t p, output sweep_result_t r);
    logic [63:0] r2, cut2;
    r = '0;
    if (p.ref_index != p.other_index) begin
      r2 = axis_sq(wrap_delta(p.other_x, p.ref_x))
         + axis_sq(wrap_delta(p.other_y, p.ref_y))
         + axis_sq(wrap_delta(p.other_z, p.ref_z));
      cut2 = 64'(cfg_cutoff) * 64'(cfg_cutoff);
      if (r2 < cut2) accumulate_term(lj_term(r2));
    end
    if (!p.last_particle) return 1'b0;
    r.energy_sum      = pred_sum;
    r.near_zero_error = pred_near;
    r.sum_saturated   = pred_clamp;
    pred_sum   = '0;
    pred_near  = 1'b0;
    pred_clamp = 1'b0;
    return 1'b1;
  endfunction

  function automatic stim_row_t make_row(input int cx, cy, cz, ox, oy, oz,
                                         input int ci, oi, input bit last,
                                         input bit typed, input logic [63:0] e,
                                         input bit nz, input bit sat);
    stim_row_t row;
    row.pair = '{POS_W'(cx), POS_W'(cy), POS_W'(cz), POS_W'(ox), POS_W'(oy),
                 POS_W'(oz), IDX_W'(ci), IDX_W'(oi), last};
    row.typed = typed;
    row.res   = '{e, nz, sat};
    return row;
  endfunction

  function automatic logic [POS_W-1:0] pos_in_box(input logic [CFG_W-1:0] box);
    if (box == 0) return '0;
    return POS_W'($urandom_range(0, int'(box) - 1));
  endfunction

  function automatic logic [POS_W-1:0] pos_near(input logic [POS_W-1:0] base,
                                                input int c);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * c)) - c;
    return v[POS_W-1:0];
  endfunction

  // Entered and left at a falling edge.
  task automatic send_pair(input pair_t p, input bit typed_on,
                           input sweep_result_t typed);
    int            gap;
    bit            due;
    sweep_result_t want;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.ref_x         <= p.ref_x;
    item_ch.ref_y         <= p.ref_y;
    item_ch.ref_z         <= p.ref_z;
    item_ch.other_x       <= p.other_x;
    item_ch.other_y       <= p.other_y;
    item_ch.other_z       <= p.other_z;
    item_ch.ref_index     <= p.ref_index;
    item_ch.other_index   <= p.other_index;
    item_ch.last_particle <= p.last_particle;
    item_ch.valid         <= 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    due = predict_pair(p, want);
    if (due) sweep_q.push_back(typed_on ? typed : want);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] box, cut, sig, eps);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BOX_LENGTH;
    cfg_data  <= box;
    @(negedge clk);
    cfg_index <= REG_CUTOFF_RADIUS;
    cfg_data  <= cut;
    @(negedge clk);
    cfg_index <= REG_SIGMA_LENGTH;
    cfg_data  <= sig;
    @(negedge clk);
    cfg_index <= REG_EPSILON_DEPTH;
    cfg_data  <= eps;
    @(negedge clk);
    cfg_we     <= 1'b0;
    cfg_box    = box;
    cfg_cutoff = cut;
    cfg_sigma  = sig;
    cfg_eps    = eps;
  endtask

  // Waits for every outstanding sum, then lets a request with no result finish.
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (sweep_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] box, cut, sig, eps,
                           input int n_items, input bit src_on, snk_on,
                           input bit short_sweeps, input bit hold);
    int    sent, span, pick, c;
    pair_t p;
    load_settings(box, cut, sig, eps);
    src_idle  = src_on;
    sink_idle = snk_on;
    if (hold) hold_go = 1'b1;
    c = (cut > 24'h3FFFFF) ? 32'h3FFFFF : int'(cut);
    sent = 0;
    while (sent < n_items) begin
      span = short_sweeps ? $urandom_range(1, 3) : $urandom_range(1, 24);
      if (sent + span > n_items) span = n_items - sent;
      p.ref_x = pos_in_box(box);
      p.ref_y = pos_in_box(box);
      p.ref_z = pos_in_box(box);
      p.ref_index = IDX_W'($urandom_range(0, 1023));
      for (int k = 0; k < span; k++) begin
        // Now and then the chosen particle moves mid-sweep.
        if ($urandom_range(0, 19) == 0) begin
          p.ref_x = POS_W'($urandom);
          p.ref_y = POS_W'($urandom);
          p.ref_z = POS_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          p.other_x = pos_near(p.ref_x, c);
          p.other_y = pos_near(p.ref_y, c);
          p.other_z = pos_near(p.ref_z, c);
        end else if (pick < 85) begin
          p.other_x = pos_in_box(box);
          p.other_y = pos_in_box(box);
          p.other_z = pos_in_box(box);
        end else if (pick < 95) begin
          p.other_x = POS_W'($urandom);
          p.other_y = POS_W'($urandom);
          p.other_z = POS_W'($urandom);
        end else begin
          p.other_x = p.ref_x;
          p.other_y = p.ref_y;
          p.other_z = p.ref_z;
        end
        p.other_index = ($urandom_range(0, 9) == 0) ? p.ref_index
                                                    : IDX_W'($urandom_range(0, 1023));
        p.last_particle = (k == span - 1);
        send_pair(p, 1'b0, '0);
      end
      sent += span;
    end
    settle();
  endtask

  // Receiver: a random stall before each sum while sink_idle is set, and one long hold-off.
  always @(negedge clk) begin
    if (hold_off || sink_stall > 0) result_ch.ready <= 1'b0;
    else result_ch.ready <= 1'b1;
    if (!hold_off && sink_stall > 0) sink_stall = sink_stall - 1;
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    sweep_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      sink_stall = sink_idle ? $urandom_range(0, 3) : 0;
      if (sweep_q.size() == 0) begin
        note_failure($sformatf("sum with no sweep pending: energy_sum %h",
                               result_ch.energy_sum));
      end else begin
        want = sweep_q.pop_front();
        if (result_ch.energy_sum !== want.energy_sum)
          note_failure($sformatf("energy_sum: expected %h, got %h",
                                 want.energy_sum, result_ch.energy_sum));
        if (result_ch.near_zero_error !== want.near_zero_error)
          note_failure($sformatf("near_zero_error: expected %b, got %b",
                                 want.near_zero_error, result_ch.near_zero_error));
        if (result_ch.sum_saturated !== want.sum_saturated)
          note_failure($sformatf("sum_saturated: expected %b, got %b",
                                 want.sum_saturated, result_ch.sum_saturated));
      end
    end
  end

  // Watchdog on cycles with no request accepted on either channel.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no request accepted for %0d cycles", QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] box, cut, sig, eps;
    int mx;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    item_ch.valid         = 1'b0;
    item_ch.ref_x         = '0;
    item_ch.ref_y         = '0;
    item_ch.ref_z         = '0;
    item_ch.other_x       = '0;
    item_ch.other_y       = '0;
    item_ch.other_z       = '0;
    item_ch.ref_index     = '0;
    item_ch.other_index   = '0;
    item_ch.last_particle = 1'b0;
    result_ch.ready       = 1'b0;
    cfg_box    = BOX_LENGTH_RST;
    cfg_cutoff = CUTOFF_RADIUS_RST;
    cfg_sigma  = SIGMA_LENGTH_RST;
    cfg_eps    = EPSILON_DEPTH_RST;
    pred_sum   = '0;
    pred_near  = 1'b0;
    pred_clamp = 1'b0;
    mx = 24'hFFFFFF;

    // Directed sweeps at the reset settings: box 10, cutoff 3, sigma 1, eps 1.
    // Self pair: nothing is added.
    directed_rows.push_back(make_row(2*ONE, 2*ONE, 2*ONE, 163840, 2*ONE, 2*ONE,
                                     5, 5, 1, 1, 64'd0, 0, 0));
    // Coincident particles clamp the term.
    directed_rows.push_back(make_row(4*ONE, 4*ONE, 4*ONE, 4*ONE, 4*ONE, 4*ONE,
                                     0, 1023, 1, 1, POS_MAX, 0, 1));
    // Exactly half a box apart stays unwrapped and lies outside the cutoff.
    directed_rows.push_back(make_row(ONE, ONE, ONE, 6*ONE, ONE, ONE,
                                     1, 2, 1, 1, 64'd0, 0, 0));
    // At r = sigma the term is zero, so the near-zero flag is raised.
    directed_rows.push_back(make_row(ONE, ONE, ONE, 2*ONE, ONE, ONE,
                                     1, 2, 1, 1, 64'd0, 1, 0));
    // r = 0.1: q fits but the term overflows.
    directed_rows.push_back(make_row(3*ONE, 3*ONE, 3*ONE, 3*ONE + 6554, 3*ONE, 3*ONE,
                                     3, 4, 1, 1, POS_MAX, 0, 1));
    // One raw unit apart: q itself overflows.
    directed_rows.push_back(make_row(3*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE, 3*ONE + 1,
                                     7, 8, 1, 1, POS_MAX, 0, 1));
    // Two clamped terms saturate the sum.
    directed_rows.push_back(make_row(5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE,
                                     3, 4, 0, 0, 64'd0, 0, 0));
    directed_rows.push_back(make_row(5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE,
                                     3, 9, 1, 1, POS_MAX, 0, 1));
    // A mixed sweep from the origin, checked by the predictor.
    directed_rows.push_back(make_row(0, 0, 0, 622592, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(0, 0, 0, mx, mx, mx, 0, 1023, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(0, 0, 0, 73562, 0, 0, 0, 2, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(0, 0, 0, 0, 58982, 0, 0, 3, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(0, 0, 0, 0, 0, 98304, 0, 4, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    // Chosen particle at the top of the field range; accumulation goes on
    // after the near-zero flag has been raised.
    directed_rows.push_back(make_row(mx, mx, mx, 0, 0, 0, 1023, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(mx, mx, mx, mx - ONE, mx, mx,
                                     1023, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(mx, mx, mx, mx, mx - 98304, mx,
                                     1023, 2, 1, 0, 0, 0, 0));
    // Just inside and exactly at the cutoff.
    directed_rows.push_back(make_row(5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 8*ONE - 1,
                                     10, 11, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 8*ONE,
                                     10, 12, 1, 0, 0, 0, 0));
    // A difference below minus half a box wraps upwards.
    directed_rows.push_back(make_row(638976, ONE, ONE, 16384, ONE, ONE,
                                     20, 21, 1, 0, 0, 0, 0));

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].res);
    settle();

    run_phase(10*ONE, 3*ONE, ONE, ONE, 120, 1, 1, 0, 0);
    run_phase(24'hFFFFFF, 24'hFFFFFF, ONE, 24'hFFFFFF, 100, 0, 0, 0, 0);
    run_phase(24'd1, 24'd1, 24'd1, 24'd0, 60, 1, 0, 0, 0);
    run_phase(20*ONE, 8*ONE, 24'hFFFFFF, ONE, 80, 0, 1, 0, 0);
    // Short sweeps against a long receiver hold-off, so the block backs up.
    run_phase(10*ONE, 3*ONE, ONE, ONE, 60, 0, 1, 1, 1);
    repeat (5) begin
      box = CFG_W'($urandom_range(2*ONE, 40*ONE));
      cut = CFG_W'($urandom_range(ONE/2, 6*ONE));
      sig = CFG_W'($urandom_range(ONE/4, 3*ONE));
      eps = CFG_W'($urandom_range(ONE/16, 8*ONE));
      run_phase(box, cut, sig, eps, 100, $urandom_range(0, 9) < 7,
                $urandom_range(0, 9) < 7, 0, 0);
    end

    if (sweep_q.size() != 0)
      note_failure($sformatf("%0d sweep sums never arrived", sweep_q.size()));
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
